/* hdl/erpm_pkg.sv */
package erpm_pkg;

    // field widths
    localparam int PERIOD_BITS    = 16;
    localparam int CCF_BITS       = 4;
    localparam int SPEED_BITS     = 16;
    localparam int THR_BITS       = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // one minute holds 6e6 steps of 10 us
    localparam int RPM_CONST      = 6000000;
    localparam int RPM_CONST_BITS = $clog2(RPM_CONST + 1);
    localparam logic [RPM_CONST_BITS-1:0] RPM_CONST_VEC = RPM_CONST_BITS'(RPM_CONST);

    // divider geometry: one quotient bit per pipeline step
    localparam int QUOT_BITS   = RPM_CONST_BITS + CCF_BITS;
    localparam int SCALE_BITS  = 6;
    localparam int DENK_BITS   = CCF_BITS + SCALE_BITS;
    localparam int DRPM_BITS   = PERIOD_BITS + CCF_BITS;
    localparam int DIVR_BITS   = PERIOD_BITS + DENK_BITS;
    localparam int TENS_BITS   = QUOT_BITS + 4;
    localparam int NUM_LANES   = 3;

    // divider lanes: plain rpm from the latest period, scaled latest, scaled filtered
    localparam int LANE_RPM  = 0;
    localparam int LANE_LAST = 1;
    localparam int LANE_FILT = 2;

    localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CCF_NUM        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CCF_DEN        = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SLOW_THRESHOLD = 2'd2;

    typedef enum logic [1:0] {
        UNIT_RPS,
        UNIT_RPM,
        UNIT_RPM_TENS,
        UNIT_BAD
    } unit_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_STOPPED,
        ST_OVERFLOW,
        ST_BAD_UNIT
    } status_t;

    typedef struct packed {
        logic [PERIOD_BITS-1:0] last_period;
        logic [PERIOD_BITS-1:0] filtered_period;
        unit_t                  unit;
    } in_t;

    typedef struct packed {
        logic [SPEED_BITS-1:0] speed;
        status_t               status;
    } out_t;

    typedef struct packed {
        logic [CCF_BITS-1:0] ccf_num;
        logic [CCF_BITS-1:0] ccf_den;
        logic [THR_BITS-1:0] slow_threshold;
    } cfg_t;

    // one item in flight through the divider
    typedef struct packed {
        logic [QUOT_BITS-1:0]                  num;
        logic [NUM_LANES-1:0][DIVR_BITS-1:0]   divr;
        logic [NUM_LANES-1:0][DIVR_BITS-1:0]   rem;
        logic [NUM_LANES-1:0][QUOT_BITS-1:0]   quot;
        logic                                  stopped;
        logic                                  last_zero;
        logic                                  filt_zero;
        unit_t                                 unit;
    } pipe_t;

    typedef struct packed {
        logic [DIVR_BITS-1:0] rem;
        logic                 q;
    } step_t;

    // one restoring division step
    function automatic step_t div_step(input logic [DIVR_BITS-1:0] rem,
                                       input logic [DIVR_BITS-1:0] divr,
                                       input logic nbit);
        logic [DIVR_BITS:0] shifted;
        logic [DIVR_BITS:0] diff;
        step_t              res;
        shifted = {rem, nbit};
        diff    = shifted - {1'b0, divr};
        if (diff[DIVR_BITS])
        begin
            res.rem = shifted[DIVR_BITS-1:0];
            res.q   = 1'b0;
        end
        else
        begin
            res.rem = diff[DIVR_BITS-1:0];
            res.q   = 1'b1;
        end
        return res;
    endfunction

endpackage

/* hdl/erpm_prep.sv */
module erpm_prep
    import erpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  in_t   up_data,
    input  cfg_t  cfg,
    input  logic  down_ready,
    output logic  ready,
    output logic  valid,
    output pipe_t data
);

    logic                 valid_reg;
    pipe_t                data_reg;
    pipe_t                data_next;
    logic [DENK_BITS-1:0] den_ext;
    logic [DENK_BITS-1:0] den_k;
    logic [DRPM_BITS-1:0] d_rpm;
    logic [DIVR_BITS-1:0] d_last;
    logic [DIVR_BITS-1:0] d_filt;

    // unit scale folded into the denominator: x60 for rps, x10 for tens
    always_comb
    begin
        den_ext = DENK_BITS'(cfg.ccf_den);
        case (up_data.unit)
            UNIT_RPS:      den_k = (den_ext << 6) - (den_ext << 2);
            UNIT_RPM_TENS: den_k = (den_ext << 3) + (den_ext << 1);
            default:       den_k = den_ext;
        endcase
    end

    // divisors and numerator
    assign d_rpm  = DRPM_BITS'(up_data.last_period) * DRPM_BITS'(cfg.ccf_den);
    assign d_last = DIVR_BITS'(up_data.last_period) * DIVR_BITS'(den_k);
    assign d_filt = DIVR_BITS'(up_data.filtered_period) * DIVR_BITS'(den_k);

    always_comb
    begin
        data_next                 = '0;
        data_next.num             = QUOT_BITS'(RPM_CONST_VEC) * QUOT_BITS'(cfg.ccf_num);
        data_next.divr[LANE_RPM]  = DIVR_BITS'(d_rpm);
        data_next.divr[LANE_LAST] = d_last;
        data_next.divr[LANE_FILT] = d_filt;
        data_next.stopped         = &up_data.last_period;
        data_next.last_zero       = (up_data.last_period == '0) || (cfg.ccf_den == '0);
        data_next.filt_zero       = (up_data.filtered_period == '0) || (cfg.ccf_den == '0);
        data_next.unit            = up_data.unit;
    end

    // stage moves on when empty or when the next one takes its item
    assign ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* hdl/erpm_div_step.sv */
module erpm_div_step
    import erpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  pipe_t up_data,
    input  logic  down_ready,
    output logic  ready,
    output logic  valid,
    output pipe_t data
);

    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;
    logic  nbit;
    step_t steps [NUM_LANES];

    // next numerator bit feeds all three lanes
    assign nbit = up_data.num[QUOT_BITS-1];

    always_comb
    begin
        data_next     = up_data;
        data_next.num = up_data.num << 1;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            steps[l]          = div_step(up_data.rem[l], up_data.divr[l], nbit);
            data_next.rem[l]  = steps[l].rem;
            data_next.quot[l] = {up_data.quot[l][QUOT_BITS-2:0], steps[l].q};
        end
    end

    assign ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* hdl/erpm_fmt.sv */
module erpm_fmt
    import erpm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  up_valid,
    input  pipe_t up_data,
    input  cfg_t  cfg,
    input  logic  stall,
    output logic  ready,
    output logic  valid,
    output out_t  data
);

    logic                 valid_reg;
    out_t                 data_reg;
    out_t                 data_next;
    logic                 use_filt;
    logic                 finite;
    logic [QUOT_BITS-1:0] chosen;
    logic [TENS_BITS-1:0] scaled;

    // pick the period and apply the rounding to tens
    always_comb
    begin
        use_filt = up_data.quot[LANE_RPM] < QUOT_BITS'(cfg.slow_threshold);
        finite   = !up_data.last_zero && !(use_filt && up_data.filt_zero);
        chosen   = use_filt ? up_data.quot[LANE_FILT] : up_data.quot[LANE_LAST];
        if (up_data.unit == UNIT_RPM_TENS)
        begin
            scaled = TENS_BITS'({chosen, 3'b000}) + TENS_BITS'({chosen, 1'b0});
        end
        else
        begin
            scaled = TENS_BITS'(chosen);
        end
    end

    // status in order of precedence
    always_comb
    begin
        if (up_data.stopped)
        begin
            data_next.speed  = '0;
            data_next.status = ST_STOPPED;
        end
        else if (up_data.unit == UNIT_BAD)
        begin
            data_next.speed  = SPEED_MAX;
            data_next.status = ST_BAD_UNIT;
        end
        else if (!finite || (scaled > TENS_BITS'(SPEED_MAX)))
        begin
            data_next.speed  = SPEED_MAX;
            data_next.status = ST_OVERFLOW;
        end
        else
        begin
            data_next.speed  = scaled[SPEED_BITS-1:0];
            data_next.status = ST_OK;
        end
    end

    // output register doubles as the skid between pipeline and receiver
    assign ready = !valid_reg || !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

/* hdl/engine_rpm_from_period.sv */
// engine speed from ignition period
// input channel in_valid / in_stall / in_data carries the latest and the
// filtered ignition period (10 us steps) and a unit code; every accepted
// transaction gives exactly one output transaction on out_valid / out_stall /
// out_data with the speed and a status code
// configuration: cfg_we with cfg_index and cfg_data writes ccf_num, ccf_den or
// slow_threshold in one cycle; write only while no transaction is in flight
// latency: 29 cycles from input to output when nothing stalls, one prep
// stage, one restoring-divider stage per quotient bit (27) and a format stage
// throughput: one transaction per cycle; three divider lanes run side by side
// so the slow-speed fallback costs no extra pass
// reset clears every stage valid bit and loads ccf_num 1, ccf_den 1 and
// slow_threshold 1000
// when the receiver stalls the output holds, empty stages keep filling and
// in_stall rises only once every stage holds a transaction
module engine_rpm_from_period
    import erpm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_t                       in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_t                      out_data,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    logic [CCF_BITS-1:0] ccf_num_reg;
    logic [CCF_BITS-1:0] ccf_den_reg;
    logic [THR_BITS-1:0] slow_threshold_reg;
    cfg_t                cfg;
    logic                in_ready;

    pipe_t              stage_data  [QUOT_BITS+1];
    logic [QUOT_BITS:0] stage_valid;
    logic [QUOT_BITS:0] stage_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ccf_num_reg        <= CCF_BITS'(1);
            ccf_den_reg        <= CCF_BITS'(1);
            slow_threshold_reg <= THR_BITS'(1000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CCF_NUM:        ccf_num_reg        <= cfg_data[CCF_BITS-1:0];
                CFG_CCF_DEN:        ccf_den_reg        <= cfg_data[CCF_BITS-1:0];
                CFG_SLOW_THRESHOLD: slow_threshold_reg <= cfg_data[THR_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.ccf_num        = ccf_num_reg;
    assign cfg.ccf_den        = ccf_den_reg;
    assign cfg.slow_threshold = slow_threshold_reg;

    // divisors, numerator and flags
    erpm_prep u_prep
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (in_valid),
        .up_data    (in_data),
        .cfg        (cfg),
        .down_ready (stage_ready[0]),
        .ready      (in_ready),
        .valid      (stage_valid[0]),
        .data       (stage_data[0])
    );

    assign in_stall = !in_ready;

    // divider chain, one quotient bit per stage
    for (genvar g = 0; g < QUOT_BITS; g++)
    begin : g_div
        erpm_div_step u_step
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stage_valid[g]),
            .up_data    (stage_data[g]),
            .down_ready (stage_ready[g+1]),
            .ready      (stage_ready[g]),
            .valid      (stage_valid[g+1]),
            .data       (stage_data[g+1])
        );
    end

    // period choice, unit rounding and status
    erpm_fmt u_fmt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (stage_valid[QUOT_BITS]),
        .up_data  (stage_data[QUOT_BITS]),
        .cfg      (cfg),
        .stall    (out_stall),
        .ready    (stage_ready[QUOT_BITS]),
        .valid    (out_valid),
        .data     (out_data)
    );

    // a free receiver leaves every stage free to move
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output is free");

    // error codes always carry the saturated speed
    a_err_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == ST_OVERFLOW || out_data.status == ST_BAD_UNIT)
        |-> out_data.speed == SPEED_MAX)
        else $error("error status without saturated speed");

    // a stopped engine reports zero
    a_stop_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_STOPPED |-> out_data.speed == '0)
        else $error("stopped status with nonzero speed");

endmodule
